// ===== src/hwd_pkg.sv =====
// ----------------------------------------------------------------------------
// hwd_pkg
// Shared constants and types for the hysteresis window detector.
// ----------------------------------------------------------------------------
package hwd_pkg;

   localparam int SAMPLE_BITS_DEF = 32;
   localparam int INDEX_BITS_DEF  = 24;
   localparam int CSR_INDEX_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ON_LEVEL  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFF_LEVEL = CSR_INDEX_BITS'(1);

   // control flags handed from the tracker to the result register
   typedef struct packed {
      logic hit;        // a window closed on this word
      logic saturated;  // index counter reached its maximum in this record
   } event_type;

endpackage

// ===== src/hwd_track.sv =====
// ----------------------------------------------------------------------------
// hwd_track
// Record state and threshold compares; flags a closed window per word.
// ----------------------------------------------------------------------------
module hwd_track #(
   parameter int SAMPLE_BITS = hwd_pkg::SAMPLE_BITS_DEF,
   parameter int INDEX_BITS  = hwd_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          first,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] on_level,
   input  logic signed [SAMPLE_BITS-1:0] off_level,
   output hwd_pkg::event_type            evt,
   output logic        [INDEX_BITS-1:0]  win_start,
   output logic        [INDEX_BITS-1:0]  win_end
);

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic        [INDEX_BITS-1:0]  index_ff, index_in;
   logic        [INDEX_BITS-1:0]  start_ff, start_in;
   logic                          open_ff, open_in;
   logic                          sat_ff, sat_in;
   logic                          hit;

   always_comb begin
      prev_in  = sample;
      index_in = index_ff;
      start_in = start_ff;
      open_in  = open_ff;
      sat_in   = sat_ff;
      hit      = 1'b0;
      if (first) begin
         index_in = '0;
         start_in = '0;
         sat_in   = 1'b0;
         open_in  = sample > on_level;
      end else begin
         // counter sticks at its top value
         if (index_ff != INDEX_MAX) begin
            index_in = index_ff + INDEX_BITS'(1);
         end
         sat_in = sat_ff | (index_in == INDEX_MAX);
         if (open_ff) begin
            if (prev_ff >= off_level && sample < off_level) begin
               hit     = 1'b1;
               open_in = 1'b0;
            end
         end else if (prev_ff < on_level && sample >= on_level) begin
            open_in  = 1'b1;
            start_in = index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         index_ff <= '0;
         start_ff <= '0;
         open_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (step) begin
         prev_ff  <= prev_in;
         index_ff <= index_in;
         start_ff <= start_in;
         open_ff  <= open_in;
         sat_ff   <= sat_in;
      end
   end

   assign evt.hit       = step & hit;
   assign evt.saturated = sat_in;
   assign win_start     = start_ff;
   assign win_end       = index_in;

endmodule

// ===== src/hysteresis_window_detector_unit.sv =====
// ----------------------------------------------------------------------------
// hysteresis_window_detector_unit
// Dual-threshold window detector over a stream of signed samples.
// ----------------------------------------------------------------------------
// A result appears on rsp_ in the cycle after the word that closes it.
// Throughput: one input word per cycle; the result register is the only stage
// and a new word is taken whenever it is empty or being drained.
// Reset (synchronous): both levels to zero, record state cleared, no window
// open, result register empty.
module hysteresis_window_detector_unit #(
   parameter int SAMPLE_BITS = hwd_pkg::SAMPLE_BITS_DEF,
   parameter int INDEX_BITS  = hwd_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // config write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hwd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_data,
   // sample stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample
   input  logic                                req_tuser,  // first_of_record
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((2*INDEX_BITS+7)/8)*8-1:0]   rsp_tdata,  // window_start, window_end
   output logic                                rsp_tuser   // index_saturated
);

   localparam int RSP_W = ((2*INDEX_BITS+7)/8)*8;

   logic signed [SAMPLE_BITS-1:0] on_ff, off_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [INDEX_BITS-1:0]         out_start_ff, out_end_ff;
   logic                          out_sat_ff;
   logic                          accept;
   hwd_pkg::event_type            evt;
   logic [INDEX_BITS-1:0]         win_start, win_end;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff  <= '0;
         off_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            hwd_pkg::REG_ON_LEVEL:  on_ff  <= csr_data;
            hwd_pkg::REG_OFF_LEVEL: off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = ~out_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   hwd_track #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .first     (req_tuser),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .on_level  (on_ff),
      .off_level (off_ff),
      .evt       (evt),
      .win_start (win_start),
      .win_end   (win_end)
   );

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (evt.hit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload loads only with a fresh result
   always_ff @(posedge clock) begin
      if (evt.hit) begin
         out_start_ff <= win_start;
         out_end_ff   <= win_end;
         out_sat_ff   <= evt.saturated;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_end_ff, out_start_ff});
   assign rsp_tuser  = out_sat_ff;

endmodule

// ===== src/hwd_checker.sv =====
// ----------------------------------------------------------------------------
// hwd_checker
// Port-level checks for the hysteresis window detector, bound to the top.
// ----------------------------------------------------------------------------
module hwd_checker #(
   parameter int INDEX_BITS  = hwd_pkg::INDEX_BITS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*INDEX_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   logic req_acc, rsp_hold, rsp_new;
   logic rsp_hold_ff;

   assign req_acc  = req_tvalid & req_tready;
   assign rsp_hold = rsp_tvalid & ~rsp_tready;

   // stall seen on the previous edge
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_hold_ff <= 1'b0;
      end else begin
         rsp_hold_ff <= rsp_hold;
      end
   end

   assign rsp_new = rsp_tvalid & ~rsp_hold_ff;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_hold |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a fresh result needs an accepted word just before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_new |-> $past(req_acc))
      else $error("result without an accepted sample");

   // a record start never closes a window
   a_first_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser) |=> !rsp_new)
      else $error("result on first sample of a record");

   // window never ends before it starts
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[INDEX_BITS-1:0] <= rsp_tdata[2*INDEX_BITS-1:INDEX_BITS])
      else $error("window end precedes start");

   // empty result register never blocks input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind hysteresis_window_detector_unit hwd_checker #(
   .INDEX_BITS  (INDEX_BITS)
) u_hwd_checker (.*);

// ===== tb/hysteresis_window_detector_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hysteresis_window_detector_unit_test
// Drives signed sample records through the window detector, tracks open and
// close crossings in a scoreboard and checks every emitted window in order.
// ----------------------------------------------------------------------------
module hysteresis_window_detector_unit_test;

   localparam int SW  = hwd_pkg::SAMPLE_BITS_DEF;
   localparam int IW  = hwd_pkg::INDEX_BITS_DEF;
   localparam int CIW = hwd_pkg::CSR_INDEX_BITS;
   localparam int DW  = ((SW + 7) / 8) * 8;
   localparam int RW  = ((2 * IW + 7) / 8) * 8;
   localparam logic [IW-1:0] INDEX_TOP = '1;
   localparam logic signed [SW-1:0] SAMPLE_TOP    = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_BOTTOM = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] ONE_Q16       = SW'(32'h0001_0000);
   localparam logic [CIW-1:0] REG_PAST_END = CIW'(2);

   typedef struct {
      logic [IW-1:0] start_idx;
      logic [IW-1:0] end_idx;
      bit            sat;
   } window_rec_type;

   class window_scoreboard_type;
      logic signed [SW-1:0] on_lvl, off_lvl, prev;
      logic [IW-1:0]        idx, open_start;
      bit                   open, sat;
      window_rec_type       closed_windows[$];
      int                   errors;

      function new();
         on_lvl = '0;
         off_lvl = '0;
         prev = '0;
         idx = '0;
         open_start = '0;
         open = 1'b0;
         sat = 1'b0;
         errors = 0;
      endfunction

      function void set_level(logic [CIW-1:0] reg_idx, logic [SW-1:0] val);
         if (reg_idx == hwd_pkg::REG_ON_LEVEL) on_lvl = val;
         else if (reg_idx == hwd_pkg::REG_OFF_LEVEL) off_lvl = val;
      endfunction

      function void note_sample(logic signed [SW-1:0] s, bit first);
         window_rec_type rec;
         if (first) begin
            idx = '0;
            sat = 1'b0;
            open_start = '0;
            open = (s > on_lvl);
            prev = s;
            return;
         end
         // counter sticks at the top and flags the rest of the record
         if (idx == INDEX_TOP) begin
            sat = 1'b1;
         end else begin
            idx = idx + 1'b1;
            if (idx == INDEX_TOP) sat = 1'b1;
         end
         if (open) begin
            if (prev >= off_lvl && s < off_lvl) begin
               rec.start_idx = open_start;
               rec.end_idx = idx;
               rec.sat = sat;
               closed_windows.insert(closed_windows.size(), rec);
               open = 1'b0;
            end
         end else if (prev < on_lvl && s >= on_lvl) begin
            open = 1'b1;
            open_start = idx;
         end
         prev = s;
      endfunction

      function void check_window(logic [IW-1:0] st, logic [IW-1:0] en, bit sflag);
         window_rec_type want;
         if (closed_windows.size() == 0) begin
            $error("unexpected window word: start %0d end %0d saturated %0d", st, en, sflag);
            errors++;
            return;
         end
         want = closed_windows.pop_front();
         if (st !== want.start_idx) begin
            $error("window_start: expected %0d, got %0d", want.start_idx, st);
            errors++;
         end
         if (en !== want.end_idx) begin
            $error("window_end: expected %0d, got %0d", want.end_idx, en);
            errors++;
         end
         if (sflag !== want.sat) begin
            $error("index_saturated: expected %0d, got %0d", want.sat, sflag);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CIW-1:0]            csr_index = '0;
   logic [SW-1:0]             csr_data = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DW-1:0]             req_tdata = '0;   // sample
   logic                      req_tuser = 1'b0; // first_of_record
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RW-1:0]             rsp_tdata;        // window_start, window_end
   logic                      rsp_tuser;        // index_saturated

   window_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   hysteresis_window_detector_unit #(
      .SAMPLE_BITS(SW),
      .INDEX_BITS (IW)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("hysteresis_window_detector_unit verification failed");
      $finish;
   end

   // result side: random stalls, plus a long hold-off counted down here
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(99) >= stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_window(rsp_tdata[IW-1:0], rsp_tdata[2*IW-1:IW], rsp_tuser);
      end
   end

   task automatic send_sample(input logic signed [SW-1:0] s, input bit first);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = DW'(s);
      req_tuser = first;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s, first);
   endtask

   task automatic write_reg(input logic [CIW-1:0] reg_idx,
                            input logic [SW-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = reg_idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      sb.set_level(reg_idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop sending and let every pending window come out
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.closed_windows.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      logic signed [SW-1:0] s;
      case ($urandom_range(9))
         0, 1, 2: s = sb.on_lvl + SW'($urandom_range(64)) - SW'(32);
         3, 4, 5: s = sb.off_lvl + SW'($urandom_range(64)) - SW'(32);
         6:       s = $urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
         7:       s = $urandom_range(1) ? sb.on_lvl : sb.off_lvl;
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic run_records(input int n_samples);
      int  sent;
      int  len;
      bit  carry_on;
      sent = 0;
      while (sent < n_samples) begin
         len = $urandom_range(40, 2);
         // now and then no record mark: the old record just continues
         carry_on = ($urandom_range(9) == 0);
         for (int k = 0; k < len; k++) begin
            send_sample(pick_sample(), (k == 0) && !carry_on);
            sent++;
         end
         if ($urandom_range(24) == 0) settle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both levels at zero; samples before any record mark first
      send_sample(-32'sd5, 1'b0);
      send_sample(32'sd7, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(SAMPLE_TOP, 1'b1);
      send_sample(SAMPLE_BOTTOM, 1'b0);
      send_sample(32'sd0, 1'b1);       // equal to on level: stays closed
      send_sample(32'sd0, 1'b0);
      send_sample(32'sd5, 1'b1);
      send_sample(-32'sd3, 1'b1);      // open window dropped by new record
      send_sample(32'sd0, 1'b0);
      send_sample(SAMPLE_BOTTOM, 1'b0);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(-32'sd1, 1'b0);
      settle();
      write_reg(hwd_pkg::REG_ON_LEVEL, ONE_Q16);
      write_reg(hwd_pkg::REG_OFF_LEVEL, -ONE_Q16);
      write_reg(REG_PAST_END, $urandom);
      send_sample(ONE_Q16, 1'b1);
      send_sample(32'sd0, 1'b0);
      send_sample(ONE_Q16, 1'b0);
      send_sample(-ONE_Q16, 1'b0);     // at off level: no close yet
      send_sample(-ONE_Q16 - 1, 1'b0);

      for (int seg = 0; seg < 8; seg++) begin
         settle();
         case (seg / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         case (seg)
            0: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, ONE_Q16);
               write_reg(hwd_pkg::REG_OFF_LEVEL, ONE_Q16 >>> 1);
            end
            1: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, -2 * ONE_Q16);
               write_reg(hwd_pkg::REG_OFF_LEVEL, -2 * ONE_Q16);
            end
            2: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, SAMPLE_TOP);
               write_reg(hwd_pkg::REG_OFF_LEVEL, SAMPLE_BOTTOM);
            end
            3: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, SAMPLE_BOTTOM);
               write_reg(hwd_pkg::REG_OFF_LEVEL, SAMPLE_TOP);
               write_reg(REG_PAST_END, $urandom);
            end
            4: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, -(ONE_Q16 >>> 1));
               write_reg(hwd_pkg::REG_OFF_LEVEL, ONE_Q16 >>> 1);
            end
            5: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, $urandom);
               write_reg(hwd_pkg::REG_OFF_LEVEL, $urandom);
            end
            6: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, '0);
               write_reg(hwd_pkg::REG_OFF_LEVEL, '0);
            end
            default: begin
               write_reg(hwd_pkg::REG_ON_LEVEL, 3 * ONE_Q16);
               write_reg(hwd_pkg::REG_OFF_LEVEL, -3 * ONE_Q16);
            end
         endcase
         // long result stall while words keep coming: input must back up
         if (seg == 0) hold_left = 400;
         run_records(88);
      end

      settle();
      if (sb.errors == 0 && sb.closed_windows.size() == 0) begin
         $display("hysteresis_window_detector_unit verification clean");
      end else begin
         if (sb.closed_windows.size() != 0)
            $error("%0d expected windows never came out", sb.closed_windows.size());
         $display("hysteresis_window_detector_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hwd_pkg.sv
src/hwd_track.sv
src/hysteresis_window_detector_unit.sv
src/hwd_checker.sv
tb/hysteresis_window_detector_unit_test.sv
